>>> src/sqmc_pkg.sv
// ----------------------------------------------------------------------------
// sqmc_pkg
// Types, constants and node offset tables for the structured quad mesh
// connectivity block.
// ----------------------------------------------------------------------------
package sqmc_pkg;

  localparam int CELLS_W   = 11;
  localparam int ELEM_W    = 21;
  localparam int LNODE_W   = 4;
  localparam int NODE_W    = 23;
  localparam int LAT_W     = 12;
  localparam int KIND_W    = 2;
  localparam int MULT_W    = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUAD4 = 2'd0,
    KIND_QUAD8 = 2'd1,
    KIND_QUAD9 = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_ELEM_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y   = 2'd2;

  // Per-element values latched ahead of node sequencing.
  typedef struct packed {
    logic              err;
    kind_t             kind;
    logic [ELEM_W-1:0] elem_number;
    logic [NODE_W-1:0] base;
    logic [LAT_W-1:0]  lx0;
    logic [LAT_W-1:0]  ly0;
  } elem_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  elem_number;
    logic [LNODE_W-1:0] local_node;
    logic [NODE_W-1:0]  node_number;
    logic [LAT_W-1:0]   lattice_x;
    logic [LAT_W-1:0]   lattice_y;
    logic               range_error;
    logic               last_node;
  } node_t;

  // Half-cell lattice offsets of local nodes 1..9 (index 0..8).
  function automatic logic [1:0] off_x(input logic [LNODE_W-1:0] k);
    logic [1:0] o;
    case (k)
      4'd1, 4'd2, 4'd5: o = 2'd2;
      4'd4, 4'd6, 4'd8: o = 2'd1;
      default:          o = 2'd0;
    endcase
    return o;
  endfunction

  function automatic logic [1:0] off_y(input logic [LNODE_W-1:0] k);
    logic [1:0] o;
    case (k)
      4'd2, 4'd3, 4'd6: o = 2'd2;
      4'd5, 4'd7, 4'd8: o = 2'd1;
      default:          o = 2'd0;
    endcase
    return o;
  endfunction

endpackage

>>> src/sqmc_node_gen.sv
// ----------------------------------------------------------------------------
// sqmc_node_gen
// Builds one node word from the latched element values and the node index.
// ----------------------------------------------------------------------------
module sqmc_node_gen (
  input  sqmc_pkg::elem_t                 elem,
  input  logic [sqmc_pkg::LNODE_W-1:0]    k,
  input  logic [sqmc_pkg::CELLS_W-1:0]    nx,
  output sqmc_pkg::node_t                 node
);
  import sqmc_pkg::*;

  logic [1:0]         ox, oy;
  logic [1:0]         dy;
  logic [LAT_W-1:0]   lx, ly;
  logic [MULT_W-1:0]  rowoff;
  logic [LAT_W-1:0]   xterm;
  logic [LNODE_W-1:0] k_last;

  always_comb begin
    ox = off_x(k);
    oy = off_y(k);
    if (elem.kind == KIND_QUAD4) begin
      dy = {1'b0, oy[1]};
      lx = elem.lx0 + LAT_W'(ox[1]);
      ly = elem.ly0 + LAT_W'(oy[1]);
    end else begin
      dy = oy;
      lx = elem.lx0 + LAT_W'(ox);
      ly = elem.ly0 + LAT_W'(oy);
    end

    case (dy)
      2'd0: rowoff = '0;
      2'd1: begin
        if (elem.kind == KIND_QUAD4) rowoff = MULT_W'(nx) + MULT_W'(1);
        else                         rowoff = {1'b0, nx, 1'b1};
      end
      2'd2: begin
        if (elem.kind == KIND_QUAD8) rowoff = MULT_W'(nx) + {1'b0, nx, 1'b0} + MULT_W'(2);
        else                         rowoff = {nx, 2'b10};
      end
      default: rowoff = '0;
    endcase

    // mid-side line of the eight-node kind holds one node per column
    if (elem.kind == KIND_QUAD8 && dy == 2'd1) xterm = lx >> 1;
    else                                       xterm = lx;

    case (elem.kind)
      KIND_QUAD4: k_last = 4'd3;
      KIND_QUAD8: k_last = 4'd7;
      default:    k_last = 4'd8;
    endcase

    if (elem.err) begin
      node.elem_number = '0;
      node.local_node  = LNODE_W'(1);
      node.node_number = '0;
      node.lattice_x   = '0;
      node.lattice_y   = '0;
      node.range_error = 1'b1;
      node.last_node   = 1'b1;
    end else begin
      node.elem_number = elem.elem_number;
      node.local_node  = k + LNODE_W'(1);
      node.node_number = elem.base + NODE_W'(rowoff) + NODE_W'(xterm) + NODE_W'(1);
      node.lattice_x   = lx;
      node.lattice_y   = ly;
      node.range_error = 1'b0;
      node.last_node   = (k == k_last);
    end
  end

endmodule

>>> src/structured_quad_mesh_connectivity.sv
// ----------------------------------------------------------------------------
// structured_quad_mesh_connectivity
// Emits the global node numbers and lattice positions of one grid element.
// ----------------------------------------------------------------------------
// Each accepted element word produces one result word per node: 4, 8 or 9
// for the four-, eight- and nine-node kinds, or a single error word for a
// position outside the grid or an unknown kind. Results leave at one word
// per cycle while out_ready is high; the node sequencer sets the sustained
// rate. The path is an input register, an element register fed by the two
// setup multipliers, and the result register. The next element is taken
// in while the current one is still being sequenced. Configuration is to
// be written by the user only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module structured_quad_mesh_connectivity #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sqmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sqmc_pkg::CELLS_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sqmc_pkg::CELLS_W-1:0]      in_elem_col,
  input  logic [sqmc_pkg::CELLS_W-1:0]      in_elem_row,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sqmc_pkg::ELEM_W-1:0]       out_elem_number,
  output logic [sqmc_pkg::LNODE_W-1:0]      out_local_node,
  output logic [sqmc_pkg::NODE_W-1:0]       out_node_number,
  output logic [sqmc_pkg::LAT_W-1:0]        out_lattice_x,
  output logic [sqmc_pkg::LAT_W-1:0]        out_lattice_y,
  output logic                              out_range_error,
  output logic                              out_last_node
);
  import sqmc_pkg::*;

  localparam int CELLS_MAX_CODE = (1 << CELLS_W) - 1;
  localparam int CELLS_SAT      = (MAX_CELLS > CELLS_MAX_CODE) ? CELLS_MAX_CODE : MAX_CELLS;
  localparam logic [CELLS_W-1:0] CELLS_SAT_V = CELLS_W'(CELLS_SAT);

  // configuration
  kind_t              kind_r;
  logic [CELLS_W-1:0] cells_x_r, cells_y_r;
  logic [CELLS_W-1:0] nx, ny;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_QUAD4;
      cells_x_r <= CELLS_W'(1);
      cells_y_r <= CELLS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ELEM_KIND: kind_r    <= kind_t'(cfg_wdata[KIND_W-1:0]);
        REG_CELLS_X:   cells_x_r <= cfg_wdata;
        REG_CELLS_Y:   cells_y_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign nx = (cells_x_r > CELLS_SAT_V) ? CELLS_SAT_V : cells_x_r;
  assign ny = (cells_y_r > CELLS_SAT_V) ? CELLS_SAT_V : cells_y_r;

  // handshake control
  logic  in_v_r, elem_v_r, out_v_r;
  logic  in_load, elem_load, out_load, elem_done;
  node_t node, out_r;
  logic [LNODE_W-1:0] k_r, k_nxt;

  assign out_load  = elem_v_r && (!out_v_r || out_ready);
  assign elem_done = out_load && node.last_node;
  assign elem_load = in_v_r && (!elem_v_r || elem_done);
  assign in_ready  = !in_v_r || elem_load;
  assign in_load   = in_valid && in_ready;

  // input register
  logic [CELLS_W-1:0] col_r, row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      col_r <= in_elem_col;
      row_r <= in_elem_row;
    end
  end

  // element setup
  elem_t              elem_nxt, elem_r;
  logic [CELLS_W-1:0] row_m1, col_m1;
  logic [MULT_W-1:0]  mult_k;
  logic [2*CELLS_W-1:0]      en_prod;
  logic [CELLS_W+MULT_W-1:0] base_prod;

  always_comb begin
    row_m1 = row_r - CELLS_W'(1);
    col_m1 = col_r - CELLS_W'(1);
    case (kind_r)
      KIND_QUAD4: mult_k = MULT_W'(nx) + MULT_W'(1);
      KIND_QUAD8: mult_k = MULT_W'(nx) + {1'b0, nx, 1'b0} + MULT_W'(2);
      default:    mult_k = {nx, 2'b10};
    endcase
    en_prod   = row_m1 * nx;
    base_prod = row_m1 * mult_k;

    elem_nxt.err = !(kind_r inside {KIND_QUAD4, KIND_QUAD8, KIND_QUAD9})
                   || (col_r == '0) || (row_r == '0) || (col_r > nx) || (row_r > ny);
    elem_nxt.kind        = kind_r;
    elem_nxt.elem_number = ELEM_W'(en_prod) + ELEM_W'(col_r);
    elem_nxt.base        = base_prod[NODE_W-1:0];
    if (kind_r == KIND_QUAD4) begin
      elem_nxt.lx0 = LAT_W'(col_m1);
      elem_nxt.ly0 = LAT_W'(row_m1);
    end else begin
      elem_nxt.lx0 = {col_m1, 1'b0};
      elem_nxt.ly0 = {row_m1, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_v_r <= 1'b0;
    end else if (elem_load) begin
      elem_v_r <= 1'b1;
    end else if (elem_done) begin
      elem_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_load) begin
      elem_r <= elem_nxt;
    end
  end

  // node sequencing
  sqmc_node_gen u_node_gen (
    .elem (elem_r),
    .k    (k_r),
    .nx   (nx),
    .node (node)
  );

  always_comb begin
    k_nxt = k_r;
    if (out_load) begin
      k_nxt = node.last_node ? '0 : k_r + LNODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= node;
    end
  end

  assign out_valid       = out_v_r;
  assign out_elem_number = out_r.elem_number;
  assign out_local_node  = out_r.local_node;
  assign out_node_number = out_r.node_number;
  assign out_lattice_x   = out_r.lattice_x;
  assign out_lattice_y   = out_r.lattice_y;
  assign out_range_error = out_r.range_error;
  assign out_last_node   = out_r.last_node;

endmodule
